// ===== src/mpsw_pkg.sv =====
// Package with the shared constants, item types and codes of the sliding-window point counter.
`timescale 1ns / 1ps

package mpsw_pkg;

    // Number of window cells and the width of a stored position.
    localparam int DEPTH   = 1024;
    localparam int POS_W   = 32;

    // Widths of the external fields.
    localparam int IN_POS_W = 32;
    localparam int LEN_W    = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = IDX_W + 1;
    localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [IN_POS_W-1:0] position;
        logic                start_of_set;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  window_count;
        logic [COUNT_W-1:0]  best_count;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // Commands broadcast from the controller to the row of cells.
    typedef struct packed {
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] wr_idx;
        logic [POS_W-1:0] pos;
    } chain_ctrl_t;

endpackage

// ===== src/mpsw_if.sv =====
// Valid/ready channel interfaces for the input points and the result items.
`timescale 1ns / 1ps

interface mpsw_in_if;
    logic               valid;
    logic               ready;
    mpsw_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mpsw_out_if;
    logic                valid;
    logic                ready;
    mpsw_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mpsw_cell.sv =====
// One window cell: holds a position, takes its neighbour's value on a shift or a new point on a load.
`timescale 1ns / 1ps

module mpsw_cell (
    input  logic                       clk,
    input  logic                       shift,
    input  logic                       load,
    input  logic [mpsw_pkg::POS_W-1:0] load_pos,
    input  logic [mpsw_pkg::POS_W-1:0] from_next,
    output logic [mpsw_pkg::POS_W-1:0] value
);

    logic [mpsw_pkg::POS_W-1:0] value_reg;
    logic [mpsw_pkg::POS_W-1:0] value_next;

    // A load wins over a shift, so the newest point lands even while the row moves up.
    always_comb
    begin
        value_next = value_reg;
        if (load)
        begin
            value_next = load_pos;
        end
        else if (shift)
        begin
            value_next = from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== src/mpsw_chain.sv =====
// Row of window cells with the oldest point always in cell zero.
`timescale 1ns / 1ps

module mpsw_chain (
    input  logic                       clk,
    input  mpsw_pkg::chain_ctrl_t      ctrl,
    output logic [mpsw_pkg::POS_W-1:0] head
);

    logic [mpsw_pkg::POS_W-1:0] cell_value [mpsw_pkg::DEPTH];

    for (genvar i = 0; i < mpsw_pkg::DEPTH; i++)
    begin : g_cell
        logic                       hit;
        logic [mpsw_pkg::POS_W-1:0] upstream;

        assign hit = ctrl.load && (ctrl.wr_idx == mpsw_pkg::IDX_W'(i));

        if (i == mpsw_pkg::DEPTH - 1)
        begin : g_last
            assign upstream = cell_value[i];
        end
        else
        begin : g_mid
            assign upstream = cell_value[i + 1];
        end

        mpsw_cell u_cell (
            .clk       (clk),
            .shift     (ctrl.shift),
            .load      (hit),
            .load_pos  (ctrl.pos),
            .from_next (upstream),
            .value     (cell_value[i])
        );
    end

    assign head = cell_value[0];

endmodule

// ===== src/max_points_in_sliding_window.sv =====
// Top level of the sliding-window point counter: control, registers and the row of cells.
`timescale 1ns / 1ps

// The block takes points in nondecreasing position order and, for each one, reports how many
// points lie within window_length of it (itself included), the largest such count since the
// last start_of_set, and a status: ok, position below the previous one (the window is then
// emptied and the point starts afresh), or window full (the oldest point was dropped to make
// room). The window is a row of 1024 cells with the oldest point always in the first cell.
// Points that fall out of the window are dropped one at a time, since the row of cells moves
// up by one cell per cycle and only the first cell is compared with the new point; each point
// leaves at most once. A new item is taken while the previous result still waits in the output
// register. The cells need no clearing after reset: only cells below the fill count are read.
// window_length is written through cfg_wr_en and cfg_wr_data and should only change while
// the block is idle.

module max_points_in_sliding_window (
    input  logic                       clk,
    input  logic                       rst_n,
    mpsw_in_if.sink                    points,
    mpsw_out_if.source                 results,
    input  logic                       cfg_wr_en,
    input  logic [mpsw_pkg::LEN_W-1:0] cfg_wr_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_EVICT = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [mpsw_pkg::OCC_W-1:0]    occ_reg;
    logic [mpsw_pkg::OCC_W-1:0]    occ_next;
    logic [mpsw_pkg::OCC_W-1:0]    best_reg;
    logic [mpsw_pkg::OCC_W-1:0]    best_next;
    logic [mpsw_pkg::POS_W-1:0]    prev_reg;
    logic [mpsw_pkg::POS_W-1:0]    prev_next;
    logic [mpsw_pkg::LEN_W-1:0]    len_reg;
    logic [mpsw_pkg::POS_W-1:0]    pos_reg;
    logic [mpsw_pkg::POS_W-1:0]    pos_next;
    logic [mpsw_pkg::STATUS_W-1:0] status_reg;
    logic [mpsw_pkg::STATUS_W-1:0] status_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    mpsw_pkg::out_item_t           out_data_reg;
    mpsw_pkg::out_item_t           out_data_next;

    mpsw_pkg::chain_ctrl_t         ctrl;
    logic [mpsw_pkg::POS_W-1:0]    head;
    logic [mpsw_pkg::POS_W-1:0]    in_pos;
    logic [mpsw_pkg::POS_W-1:0]    gap;
    logic                          in_fire;
    logic                          out_free;
    logic                          too_far;
    logic                          full;
    logic [mpsw_pkg::OCC_W-1:0]    occ_final;
    logic [mpsw_pkg::OCC_W-1:0]    best_final;

    // Positions are kept modulo the stored width.
    assign in_pos   = mpsw_pkg::POS_W'(points.data.position);
    assign in_fire  = points.valid && points.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign points.ready  = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // Within the window the positions never decrease and never exceed the new point, so the
    // gap to the oldest point is a plain difference and the points that leave are always
    // the oldest ones.
    assign gap     = pos_reg - head;
    assign too_far = (occ_reg != '0) &&
                     (mpsw_pkg::CMP_W'(gap) > mpsw_pkg::CMP_W'(len_reg));
    assign full    = (occ_reg == mpsw_pkg::OCC_W'(mpsw_pkg::DEPTH));

    // When the window is full the oldest point goes out as the new one comes in, so the
    // count stays where it is.
    assign occ_final  = full ? occ_reg : occ_reg + 1'b1;
    assign best_final = (occ_final > best_reg) ? occ_final : best_reg;

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        best_next      = best_reg;
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        ctrl.shift  = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.wr_idx = occ_reg[mpsw_pkg::IDX_W-1:0];
        ctrl.pos    = pos_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next    = in_pos;
                    status_next = mpsw_pkg::STATUS_OK;
                    if (points.data.start_of_set)
                    begin
                        occ_next  = '0;
                        best_next = '0;
                    end
                    else if ((occ_reg != '0) && (in_pos < prev_reg))
                    begin
                        // Out of order: start a fresh window but keep the best count.
                        occ_next    = '0;
                        status_next = mpsw_pkg::STATUS_ORDER;
                    end
                    state_next = ST_EVICT;
                end
            end

            ST_EVICT:
            begin
                if (too_far)
                begin
                    ctrl.shift = 1'b1;
                    occ_next   = occ_reg - 1'b1;
                end
                else if (out_free)
                begin
                    ctrl.shift  = full;
                    ctrl.load   = 1'b1;
                    ctrl.wr_idx = full ? mpsw_pkg::IDX_W'(occ_reg - 1'b1)
                                       : mpsw_pkg::IDX_W'(occ_reg);
                    occ_next    = occ_final;
                    best_next   = best_final;
                    prev_next   = pos_reg;

                    out_valid_next             = 1'b1;
                    out_data_next.window_count = mpsw_pkg::COUNT_W'(occ_final);
                    out_data_next.best_count   = mpsw_pkg::COUNT_W'(best_final);
                    if (full && (status_reg == mpsw_pkg::STATUS_OK))
                    begin
                        out_data_next.status = mpsw_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        out_data_next.status = status_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            best_reg      <= '0;
            prev_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            best_reg      <= best_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    mpsw_chain u_chain (
        .clk  (clk),
        .ctrl (ctrl),
        .head (head)
    );

    // The fill count never passes the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= mpsw_pkg::OCC_W'(mpsw_pkg::DEPTH))
        else $error("window fill count above the number of cells");

    // The best count since the start of a set always covers the current window.
    assert property (@(posedge clk) disable iff (!rst_n)
        best_reg >= occ_reg)
        else $error("best count below current window count");

    // The row of cells only moves while an item is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!ctrl.shift && !ctrl.load))
        else $error("cell row changed while idle");

    // An accepted item is always followed by the eviction phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EVICT))
        else $error("accepted item did not start eviction");

    // A result always counts at least the point that produced it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.window_count != '0))
        else $error("result with an empty window");

endmodule

// ===== test/max_points_in_sliding_window_tb.sv =====
// Self-checking testbench for the sliding-window point counter.
`timescale 1ns / 1ps

// Stimulus runs in three parts.
// 1. A short table of directed points and window_length writes. Expected counts are typed in
//    where they can be read off directly, and the remaining rows go through the predictor.
// 2. A fill run that pushes more than 1024 points into one window, so the full status is
//    reached. A mass eviction follows once the window length has been cut.
// 3. Random phases, each with its own window length. Most points step forward by amounts that
//    suit the length. A minority start a new set, go backwards or jump far ahead.
// Every accepted point is run through the predictor, and the expected result is queued. The
// result monitor takes the oldest expectation for every accepted result and compares it field
// by field. Both channels idle at random, except during the calm stretches.

module max_points_in_sliding_window_tb;

    // Cycles with no item accepted on either channel before the run is given up. The slowest
    // legal item evicts a full window one point per cycle.
    localparam int STALL_LIMIT = 6000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_POINTS = 70;
    localparam int FILL_POINTS = mpsw_pkg::DEPTH + 6;

    typedef enum bit {ROW_POINT, ROW_LENGTH} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [mpsw_pkg::LEN_W-1:0] value;
        logic                       sos;
        bit                         typed;
        mpsw_pkg::out_item_t        result;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [mpsw_pkg::LEN_W-1:0] cfg_wr_data;

    mpsw_in_if  point_ch ();
    mpsw_out_if result_ch ();

    // The block has a single register, so there is no index on the configuration port.
    max_points_in_sliding_window dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .points      (point_ch.sink),
        .results     (result_ch.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predictor state. The queue holds the positions that are currently in the window, with
    // the oldest position at the front.
    logic [mpsw_pkg::POS_W-1:0]   window_pos_q[$];
    logic [mpsw_pkg::COUNT_W-1:0] best_cnt;
    logic [mpsw_pkg::POS_W-1:0]   last_pos;
    logic [mpsw_pkg::LEN_W-1:0]   win_len;

    mpsw_pkg::out_item_t expected_counts[$];
    step_row_t           directed_rows[$];
    int                  error_count;
    bit                  calm;
    logic [31:0]         cur_pos;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Works out the result of one point and moves the predictor state on.
    function automatic mpsw_pkg::out_item_t predict_counts(
        input logic [mpsw_pkg::POS_W-1:0] pos, input logic sos);
        mpsw_pkg::out_item_t           res;
        logic [mpsw_pkg::STATUS_W-1:0] st;
        st = mpsw_pkg::STATUS_OK;
        if (sos)
        begin
            window_pos_q.delete();
            best_cnt = '0;
        end
        else if (window_pos_q.size() > 0 && pos < last_pos)
        begin
            // A point that goes backwards starts the window afresh but keeps the best count.
            window_pos_q.delete();
            st = mpsw_pkg::STATUS_ORDER;
        end
        while (window_pos_q.size() > 0 &&
               mpsw_pkg::POS_W'(pos - window_pos_q[0]) > win_len)
            void'(window_pos_q.pop_front());
        if (window_pos_q.size() >= mpsw_pkg::DEPTH)
        begin
            void'(window_pos_q.pop_front());
            if (st == mpsw_pkg::STATUS_OK)
                st = mpsw_pkg::STATUS_FULL;
        end
        window_pos_q.push_back(pos);
        last_pos = pos;
        if (window_pos_q.size() > best_cnt)
            best_cnt = mpsw_pkg::COUNT_W'(window_pos_q.size());
        res.window_count = mpsw_pkg::COUNT_W'(window_pos_q.size());
        res.best_count = best_cnt;
        res.status = st;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s is %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [31:0] value, input logic sos,
                           input bit typed, input int wc, input int bc,
                           input logic [mpsw_pkg::STATUS_W-1:0] st);
        step_row_t row;
        row.kind = kind;
        row.value = value;
        row.sos = sos;
        row.typed = typed;
        row.result.window_count = mpsw_pkg::COUNT_W'(wc);
        row.result.best_count = mpsw_pkg::COUNT_W'(bc);
        row.result.status = st;
        directed_rows.push_back(row);
    endtask

    // Offers one point after a random number of idle cycles, waits until it is taken and
    // queues its expected result. The task is entered and left on a falling edge.
    task automatic send_point(input logic [31:0] pos, input logic sos, input bit typed,
                              input mpsw_pkg::out_item_t typed_result);
        mpsw_pkg::out_item_t predicted;
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            point_ch.valid = 1'b0;
            @(negedge clk);
        end
        point_ch.valid = 1'b1;
        point_ch.data.position = pos;
        point_ch.data.start_of_set = sos;
        forever
        begin
            @(posedge clk);
            if (point_ch.ready)
                break;
        end
        predicted = predict_counts(pos, sos);
        expected_counts.push_back(typed ? typed_result : predicted);
        cur_pos = pos;
        @(negedge clk);
    endtask

    task automatic send_plain(input logic [31:0] pos, input logic sos);
        send_point(pos, sos, 1'b0, '0);
    endtask

    // Holds the input back until every outstanding result has been delivered.
    task automatic wait_drained();
        point_ch.valid = 1'b0;
        while (expected_counts.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_length(input logic [mpsw_pkg::LEN_W-1:0] value);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        win_len = value;
    endtask

    // The receiver stalls at random, except in the calm stretches.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = rst_n && (calm || $urandom_range(0, 99) >= 29);
        end
    end

    // Result monitor: every accepted result takes the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_counts.size() == 0)
                report_mismatch("unexpected result, window_count", result_ch.data.window_count, 0);
            else
            begin
                mpsw_pkg::out_item_t want;
                want = expected_counts.pop_front();
                if (result_ch.data.window_count !== want.window_count)
                    report_mismatch("window_count", result_ch.data.window_count,
                                    want.window_count);
                if (result_ch.data.best_count !== want.best_count)
                    report_mismatch("best_count", result_ch.data.best_count, want.best_count);
                if (result_ch.data.status !== want.status)
                    report_mismatch("status", result_ch.data.status, want.status);
            end
        end
    end

    // Watchdog: the run is abandoned if neither channel moves for too long.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("max_points_in_sliding_window_tb: done, errors");
        $finish;
    end

    initial
    begin
        logic [31:0] step_max;
        logic [31:0] pos;
        int          pick;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        point_ch.valid = 1'b0;
        point_ch.data = '0;
        error_count = 0;
        calm = 1'b0;
        cur_pos = '0;
        window_pos_q.delete();
        best_cnt = '0;
        last_pos = '0;
        win_len = '0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table. The window length is still at its reset value of zero, so
        // only points at the same position can share a window. This is the zero-gap case.
        add_row(ROW_POINT, 32'd100, 1'b0, 1'b1, 1, 1, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd100, 1'b0, 1'b1, 2, 2, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd100, 1'b0, 1'b1, 3, 3, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd101, 1'b0, 1'b1, 1, 3, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd50, 1'b0, 1'b1, 1, 3, mpsw_pkg::STATUS_ORDER);
        add_row(ROW_POINT, 32'hFFFF_FFFF, 1'b0, 1'b1, 1, 3, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1, mpsw_pkg::STATUS_OK);
        // The widest window holds the whole position range.
        add_row(ROW_LENGTH, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'h0000_0000, 1'b1, 1'b1, 1, 1, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'hFFFF_FFFF, 1'b0, 1'b1, 2, 2, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'hFFFF_FFFF, 1'b0, 1'b1, 3, 3, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'h0000_0000, 1'b0, 1'b1, 1, 3, mpsw_pkg::STATUS_ORDER);
        add_row(ROW_POINT, 32'h0000_0000, 1'b1, 1'b1, 1, 1, mpsw_pkg::STATUS_OK);
        // A short window with points exactly on its edge and just beyond it.
        add_row(ROW_LENGTH, 32'd10, 1'b0, 1'b0, 0, 0, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd5, 1'b1, 1'b1, 1, 1, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd10, 1'b0, 1'b1, 2, 2, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd15, 1'b0, 1'b1, 3, 3, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd16, 1'b0, 1'b0, 0, 0, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd26, 1'b0, 1'b0, 0, 0, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'd1000, 1'b0, 1'b0, 0, 0, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'h8000_0000, 1'b0, 1'b0, 0, 0, mpsw_pkg::STATUS_OK);
        // A new set may begin below the previous position without an order error.
        add_row(ROW_POINT, 32'h7FFF_FFFF, 1'b1, 1'b1, 1, 1, mpsw_pkg::STATUS_OK);
        add_row(ROW_POINT, 32'h7FFF_FFFE, 1'b0, 1'b1, 1, 1, mpsw_pkg::STATUS_ORDER);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LENGTH)
                write_length(directed_rows[i].value);
            else
                send_point(directed_rows[i].value, directed_rows[i].sos, directed_rows[i].typed,
                           directed_rows[i].result);
        end

        // Fill run: a long stretch with no idling on either side. Every point stays in the
        // widest window until the store overflows and the oldest points are pushed out.
        calm = 1'b1;
        write_length(32'hFFFF_FFFF);
        send_plain($urandom_range(0, 1000), 1'b1);
        for (int n = 1; n < FILL_POINTS; n++)
            send_plain(cur_pos + $urandom_range(0, 2), 1'b0);
        // Cutting the length and jumping ahead makes the block empty a full window point by
        // point.
        write_length(32'd3);
        send_plain(cur_pos + 32'd100, 1'b0);
        send_plain(cur_pos + 32'd2, 1'b0);
        calm = 1'b0;

        // Random phases. The step between points is scaled to the window length, so
        // that windows hold several points. Starts, backward steps and long jumps are mixed in.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph) inside
                0: write_length(32'd0);
                1: write_length(32'hFFFF_FFFF);
                2, 5: write_length($urandom);
                default: write_length($urandom_range(1, 40));
            endcase
            calm = (ph == 2);
            step_max = (win_len < 4) ? 32'd2 : win_len / 3;
            send_plain($urandom, 1'b1);
            for (int n = 1; n < PHASE_POINTS; n++)
            begin
                // Midway through one phase, the sender waits until every result has come back.
                if (ph == 4 && n == PHASE_POINTS / 2)
                    wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_plain($urandom, 1'b1);
                else if (pick < 9)
                begin
                    if (cur_pos == 0)
                        pos = $urandom;
                    else
                        pos = cur_pos - $urandom_range(1, (cur_pos < 1000) ? cur_pos : 1000);
                    send_plain(pos, 1'b0);
                end
                else if (pick < 13)
                    send_plain(cur_pos + $urandom, 1'b0);
                else
                    send_plain(cur_pos + $urandom_range(0, step_max), 1'b0);
            end
        end
        calm = 1'b0;

        // Let the last results drain, then allow a few more cycles for anything stray.
        point_ch.valid = 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("max_points_in_sliding_window_tb: done, clean");
        else
            $display("max_points_in_sliding_window_tb: done, errors");
        $finish;
    end

endmodule
